[rtl/sorted_key_first_last_lookup_defines.svh]
// Assertion macros for the sorted key lookup block.
// Used by the top level; needs i_clk and i_rst_n in scope.
`ifndef SORTED_KEY_FIRST_LAST_LOOKUP_DEFINES_SVH
`define SORTED_KEY_FIRST_LAST_LOOKUP_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define SKFL_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define SKFL_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

[rtl/skfl_pkg.sv]
// Shared constants and types for the sorted key lookup block.
// No dependencies.
package skfl_pkg;
    localparam int TABLE_DEPTH = 1024;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = 32;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_FIRST  = 2'd1;
    localparam logic [1:0] OP_LAST   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [KW-1:0] key;
        logic [CW-1:0]        pos;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_L_RD,
        S_L_CMP,
        S_Q_RD,
        S_Q_CMP,
        S_Q_CHK,
        S_Q_FIN
    } t_state;
endpackage

[rtl/skfl_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module skfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/sorted_key_first_last_lookup.sv]
// Top level of the sorted key table with first/last occurrence lookup.
// Depends on skfl_pkg, skfl_ram and sorted_key_first_last_lookup_defines.svh.
//
// Keys loaded by op 0 are inserted, while the table has room, into one RAM
// kept in ascending signed key order, equal keys in arrival order, each tagged
// with its 1-based arrival position. An insert walks down from the top of the
// table moving larger entries up one place, a read state and a compare state
// per moved entry, and holds the input off until it is done. A query (op 1
// first, op 2 last occurrence) is a binary search over the RAM, a read state
// and a compare state per halving step, the single RAM port with its
// registered read setting the pace; a query waits in its final state until the
// previous result has left the output register. One item is worked on at a
// time; a result waits in an output register while the next item is taken.
module sorted_key_first_last_lookup (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_op,
    input  logic signed [skfl_pkg::KW-1:0] i_key,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_found,
    output logic [skfl_pkg::CW-1:0]    o_position
);
    import skfl_pkg::*;
    `include "sorted_key_first_last_lookup_defines.svh"

    t_state               r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_lo, n_lo;
    logic [CW-1:0]        r_hi, n_hi;
    logic                 r_last, n_last;
    logic                 r_hit, n_hit;
    logic signed [KW-1:0] r_key, n_key;
    logic                 r_valid, n_valid;
    logic                 r_found, n_found;
    logic [CW-1:0]        r_pos, n_pos;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_addr;
    t_entry               ram_wdata, ram_rdata;
    logic [CW-1:0]        mid;
    logic                 accept;

    skfl_ram #(.WIDTH($bits(t_entry)), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (ram_re),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign o_stall    = (r_state != S_IDLE);
    assign accept     = i_valid && (r_state == S_IDLE);
    assign o_valid    = r_valid;
    assign o_found    = r_found;
    assign o_position = r_pos;
    assign mid        = r_lo + ((r_hi - r_lo) >> 1);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_last    = r_last;
        n_hit     = r_hit;
        n_key     = r_key;
        n_found   = r_found;
        n_pos     = r_pos;
        n_valid   = r_valid && i_stall;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = r_idx[AW-1:0];
        ram_wdata = '{key: r_key, pos: r_cnt + CW'(1)};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key  = i_key;
                    n_idx  = r_cnt;
                    n_lo   = '0;
                    n_hi   = r_cnt;
                    n_last = (i_op == OP_LAST);
                    if (i_op == OP_LOAD) begin
                        if (r_cnt < CW'(TABLE_DEPTH)) begin
                            n_state = S_L_RD;
                        end
                    end else if (i_op == OP_FIRST || i_op == OP_LAST) begin
                        n_state = S_Q_RD;
                    end
                end
            end
            S_L_RD: begin
                if (r_idx == '0) begin
                    ram_we  = 1'b1;
                    n_cnt   = r_cnt + CW'(1);
                    n_state = S_IDLE;
                end else begin
                    ram_re   = 1'b1;
                    ram_addr = AW'(r_idx - CW'(1));
                    n_state  = S_L_CMP;
                end
            end
            S_L_CMP: begin
                ram_we = 1'b1;
                // Strictly larger entries move up, so equal keys stay in arrival order.
                if (ram_rdata.key > r_key) begin
                    ram_wdata = ram_rdata;
                    n_idx     = r_idx - CW'(1);
                    n_state   = S_L_RD;
                end else begin
                    n_cnt   = r_cnt + CW'(1);
                    n_state = S_IDLE;
                end
            end
            S_Q_RD: begin
                if (r_lo < r_hi) begin
                    ram_re   = 1'b1;
                    ram_addr = mid[AW-1:0];
                    n_idx    = mid;
                    n_state  = S_Q_CMP;
                end else begin
                    n_state = S_Q_CHK;
                end
            end
            S_Q_CMP: begin
                if (r_last ? (ram_rdata.key <= r_key) : (ram_rdata.key < r_key)) begin
                    n_lo = r_idx + CW'(1);
                end else begin
                    n_hi = r_idx;
                end
                n_state = S_Q_RD;
            end
            S_Q_CHK: begin
                // First occurrence sits at the bound, last one just below it.
                n_hit   = r_last ? (r_lo != '0) : (r_lo < r_cnt);
                ram_re  = n_hit;
                ram_addr = r_last ? AW'(r_lo - CW'(1)) : r_lo[AW-1:0];
                n_state = S_Q_FIN;
            end
            S_Q_FIN: begin
                if (!r_valid || !i_stall) begin
                    n_valid = 1'b1;
                    n_found = r_hit && (ram_rdata.key == r_key);
                    n_pos   = n_found ? ram_rdata.pos : '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
        r_idx   <= n_idx;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_last  <= n_last;
        r_hit   <= n_hit;
        r_key   <= n_key;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

    `SKFL_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CW'(TABLE_DEPTH), "entry count beyond depth")
    `SKFL_ASSERT_NOW(a_found_pos, r_valid && r_found,
        r_pos != '0 && r_pos <= r_cnt, "found position outside loaded range")
    `SKFL_ASSERT_NOW(a_miss_pos, r_valid && !r_found, r_pos == '0, "miss with nonzero position")
    `SKFL_ASSERT_NEXT(a_full_load, accept && i_op == OP_LOAD && r_cnt == CW'(TABLE_DEPTH),
        r_state == S_IDLE, "load into full table was not dropped")
    `SKFL_ASSERT_NOW(a_search_range, r_state == S_Q_RD, r_lo <= r_hi && r_hi <= r_cnt,
        "search bounds out of order")
endmodule

[tb/tb_top.sv]
// Self-checking testbench for the sorted key table with first/last lookup.
// Depends on skfl_pkg and the sorted_key_first_last_lookup RTL; holds its own table model.
module tb_top;
    import skfl_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;

    typedef struct {
        logic signed [KW-1:0] key;
        logic [CW-1:0]        pos;
    } t_slot;

    typedef struct {
        logic          found;
        logic [CW-1:0] pos;
    } t_answer;

    // Keeps a stably sorted copy of the table and the answers still owed by the block.
    class lookup_scoreboard;
        t_slot   table_q[$];
        t_answer answers_q[$];
        int      n_errors;

        function void note_item(logic [1:0] op, logic signed [KW-1:0] key);
            t_slot   s;
            t_answer a;
            int      at;
            if (op == OP_LOAD) begin
                if (table_q.size() < TABLE_DEPTH) begin
                    at = table_q.size();
                    for (int i = 0; i < table_q.size(); i++) begin
                        if (table_q[i].key > key) begin
                            at = i;
                            break;
                        end
                    end
                    s.key = key;
                    s.pos = CW'(table_q.size() + 1);
                    table_q.insert(at, s);
                end
            end else if (op == OP_FIRST || op == OP_LAST) begin
                a.found = 1'b0;
                a.pos = '0;
                for (int i = 0; i < table_q.size(); i++) begin
                    if (table_q[i].key == key) begin
                        a.pos = table_q[i].pos;
                        if (!a.found || op == OP_LAST) begin
                            a.found = 1'b1;
                            if (op == OP_FIRST) break;
                        end
                    end
                end
                answers_q.insert(answers_q.size(), a);
            end
        endfunction

        function void check_result(logic found, logic [CW-1:0] pos);
            t_answer a;
            if (answers_q.size() == 0) begin
                $error("result with no query outstanding: found %0d position %0d", found, pos);
                n_errors++;
                return;
            end
            a = answers_q.pop_front();
            if (found !== a.found) begin
                $error("found: expected %0d, got %0d", a.found, found);
                n_errors++;
            end
            if (pos !== a.pos) begin
                $error("position: expected %0d, got %0d", a.pos, pos);
                n_errors++;
            end
        endfunction

        function int pending();
            return answers_q.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [1:0]           i_op = OP_LOAD;
    logic signed [KW-1:0] i_key = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b1;
    logic                 o_found;
    logic [CW-1:0]        o_position;

    lookup_scoreboard     sb = new();
    logic signed [KW-1:0] key_pool[12];
    bit                   no_idle = 1'b0;
    int                   n_results = 0;
    int                   n_cycles = 0;

    sorted_key_first_last_lookup u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_op(i_op), .i_key(i_key),
        .o_valid(o_valid), .i_stall(i_stall), .o_found(o_found), .o_position(o_position)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_found, o_position);
            n_results <= n_results + 1;
        end
    end

    // Result side: random hold-offs per item, and one long hold so that the block backs up.
    initial begin
        int  n;
        bit  long_done;
        long_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!long_done && n_results >= 40) begin
                long_done = 1'b1;
                n = 400;
            end else begin
                n = no_idle ? 0 : $urandom_range(0, 11);
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    task automatic send_item(logic [1:0] op, logic signed [KW-1:0] key);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_key <= key;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(op, key);
    endtask

    function automatic logic signed [KW-1:0] pick_key();
        if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 11)];
        return $urandom();
    endfunction

    task automatic send_random(int load_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < load_pct) send_item(OP_LOAD, pick_key());
        else if (r < 96) send_item(r[0] ? OP_FIRST : OP_LAST, pick_key());
        else send_item(OP_UNUSED, $urandom());
    endtask

    initial begin
        int wait_cycles;
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7fff_ffff;
        key_pool[2] = 0;
        key_pool[3] = -1;
        key_pool[4] = 1;
        for (int i = 5; i < 12; i++) key_pool[i] = $urandom();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table, unused opcode, extremes and equal keys.
        send_item(OP_FIRST, 0);
        send_item(OP_LAST, 32'sh7fff_ffff);
        send_item(OP_UNUSED, 32'sh5555_aaaa);
        send_item(OP_LOAD, 32'sh7fff_ffff);
        send_item(OP_LOAD, 32'sh8000_0000);
        send_item(OP_LOAD, 5);
        send_item(OP_LOAD, 5);
        send_item(OP_LOAD, -3);
        send_item(OP_LOAD, 5);
        send_item(OP_LOAD, 32'sh8000_0000);
        send_item(OP_FIRST, 5);
        send_item(OP_LAST, 5);
        send_item(OP_FIRST, 32'sh8000_0000);
        send_item(OP_LAST, 32'sh8000_0000);
        send_item(OP_FIRST, 32'sh7fff_ffff);
        send_item(OP_LAST, 32'sh7fff_ffff);
        send_item(OP_FIRST, 4);
        send_item(OP_LAST, 6);
        send_item(OP_FIRST, -3);
        send_item(OP_UNUSED, 32'sh2aaa_5555);

        for (int i = 0; i < 1000; i++) begin
            if (i % 200 == 150) no_idle = 1'b1;
            if (i % 200 == 0) no_idle = 1'b0;
            send_random(45);
        end
        no_idle = 1'b0;

        // Top up with the largest key, which always lands at the end, then run past full.
        while (sb.table_q.size() < TABLE_DEPTH + 20) begin
            send_item(OP_LOAD, 32'sh7fff_ffff);
            if (sb.table_q.size() == TABLE_DEPTH) break;
        end
        for (int i = 0; i < 20; i++) send_item(OP_LOAD, pick_key());
        for (int i = 0; i < 300; i++) send_random(20);
        i_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (50) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

[sorted_key_first_last_lookup.f]
+incdir+rtl
rtl/skfl_pkg.sv
rtl/skfl_ram.sv
rtl/sorted_key_first_last_lookup.sv
tb/tb_top.sv
